// File: src/fcp_pkg.sv
// Shared types, constants and the code unit classifier of the format code text parser.
package fcp_pkg;

   localparam logic [15:0] SECT_SIGN  = 16'h00A7;
   localparam logic [15:0] HASH_SIGN  = 16'h0023;
   localparam logic [15:0] EVENT_CHAR = 16'hFC00;

   localparam logic [7:0] SCHEME_COUNT_RESET = 8'd16;

   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_EVENT   = 1'b1;

   localparam logic [1:0] CM_NONE   = 2'd0;
   localparam logic [1:0] CM_DIRECT = 2'd1;
   localparam logic [1:0] CM_SCHEME = 2'd2;

   // Bit positions in the style flag word.
   localparam int FB_HAS    = 0;
   localparam int FB_BOLD   = 1;
   localparam int FB_STRIKE = 2;
   localparam int FB_UNDER  = 3;
   localparam int FB_RAND   = 4;

   localparam logic [15:0] PALETTE [16] = '{
      16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'hA800, 16'hA815, 16'hFD40, 16'hAD55,
      16'h52AA, 16'h52BF, 16'h57EA, 16'h57FF, 16'hFAAA, 16'hFABF, 16'hFFEA, 16'hFFFF
   };

   typedef enum logic [2:0] {
      LT_OTHER, LT_X, LT_Y, LT_L, LT_M, LT_N, LT_K, LT_R
   } letter_type;

   typedef struct packed {
      logic [15:0] unit;
      logic        is_sect;
      logic        is_hash;
      logic        hex_ok;
      logic [3:0]  hex_val;
      letter_type  letter;
   } unit_type;

   typedef struct packed {
      unit_type cls;
      logic     fin;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] char_out;
      logic [4:0]  flags;
      logic [1:0]  color_mode;
      logic [15:0] color565;
      logic [6:0]  scheme_index;
      logic        text_end;
      logic        last;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_RUN, ST_END
   } state_type;

   function automatic unit_type classify(input logic [15:0] u);
      unit_type c;
      logic [15:0] d;
      c.unit    = u;
      c.is_sect = (u == SECT_SIGN);
      c.is_hash = (u == HASH_SIGN);
      c.hex_ok  = 1'b0;
      c.hex_val = 4'd0;
      d         = 16'd0;
      if (u inside {[16'h0030:16'h0039]}) begin
         c.hex_ok  = 1'b1;
         c.hex_val = u[3:0];
      end else if (u inside {[16'h0061:16'h0066]}) begin
         d         = u - 16'h0057;
         c.hex_ok  = 1'b1;
         c.hex_val = d[3:0];
      end else if (u inside {[16'h0041:16'h0046]}) begin
         d         = u - 16'h0037;
         c.hex_ok  = 1'b1;
         c.hex_val = d[3:0];
      end
      case (u)
         16'h0078, 16'h0058: c.letter = LT_X;
         16'h0079, 16'h0059: c.letter = LT_Y;
         16'h006C, 16'h004C: c.letter = LT_L;
         16'h006D, 16'h004D: c.letter = LT_M;
         16'h006E, 16'h004E: c.letter = LT_N;
         16'h006B, 16'h004B: c.letter = LT_K;
         16'h0072, 16'h0052: c.letter = LT_R;
         default:            c.letter = LT_OTHER;
      endcase
      return c;
   endfunction

endpackage

// File: src/format_code_text_parser_core.sv
// Top level of the format code text parser: front queue, scan sequencer and result queue.
// Code units enter a two-beat queue and are classified on the way in. The sequencer takes
// one unit per pass: it loads the unit, then runs scan steps, each of which emits a result
// or applies a code, until a step finds nothing more to do, and then releases the final
// result. Results wait in a four-beat queue. When it fills, the sequencer stalls, the
// input queue fills up behind it, and full rises until the receiver pops again.
module format_code_text_parser_core #(
   parameter int LOOKAHEAD_DEPTH = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_code_unit,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [15:0] rsp_char_out,
   output logic        rsp_has_style,
   output logic        rsp_bold,
   output logic        rsp_strike,
   output logic        rsp_underline,
   output logic        rsp_random_glyph,
   output logic [1:0]  rsp_color_mode,
   output logic [15:0] rsp_color565,
   output logic [6:0]  rsp_scheme_index,
   output logic        rsp_text_end,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   localparam int ResW = $bits(fcp_pkg::result_type);

   logic [7:0]          scheme_count_ff;
   fcp_pkg::item_type   q_item;
   logic                q_empty, q_pop;
   logic                out_push, out_full;
   fcp_pkg::result_type out_data, head;
   logic [ResW-1:0]     head_bits;

   always_ff @(posedge clock) begin
      if (reset) scheme_count_ff <= fcp_pkg::SCHEME_COUNT_RESET;
      else if (csr_wr_en) scheme_count_ff <= csr_wr_data;
   end

   fcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .code_unit   (req_code_unit),
      .end_of_text (req_end_of_text),
      .full        (full),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .q_empty     (q_empty)
   );

   fcp_back #(.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .scheme_count (scheme_count_ff),
      .q_item       (q_item),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .out_push     (out_push),
      .out_data     (out_data),
      .out_full     (out_full)
   );

   fcp_fifo #(.WIDTH(ResW), .DEPTH(4)) u_results (
      .clock   (clock),
      .reset   (reset),
      .push_i  (out_push),
      .data_i  (out_data),
      .full_o  (out_full),
      .pop_i   (pop),
      .data_o  (head_bits),
      .empty_o (empty)
   );

   assign head             = fcp_pkg::result_type'(head_bits);
   assign rsp_kind         = head.kind;
   assign rsp_char_out     = head.char_out;
   assign rsp_has_style    = head.flags[fcp_pkg::FB_HAS];
   assign rsp_bold         = head.flags[fcp_pkg::FB_BOLD];
   assign rsp_strike       = head.flags[fcp_pkg::FB_STRIKE];
   assign rsp_underline    = head.flags[fcp_pkg::FB_UNDER];
   assign rsp_random_glyph = head.flags[fcp_pkg::FB_RAND];
   assign rsp_color_mode   = head.color_mode;
   assign rsp_color565     = head.color565;
   assign rsp_scheme_index = head.scheme_index;
   assign rsp_text_end     = head.text_end;
   assign rsp_last         = head.last;
endmodule

// File: src/fcp_fifo.sv
// Small register queue used between the parser stages and on the result side.
module fcp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  logic [WIDTH-1:0] data_i,
   output logic             full_o,
   input  logic             pop_i,
   output logic [WIDTH-1:0] data_o,
   output logic             empty_o
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full_o  = (count_ff == CW'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign data_o  = mem_ff[rd_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   always_comb begin
      wr_in    = do_push ? ((wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? ((rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= data_i;
      end
   end
endmodule

// File: src/fcp_front.sv
// Front stage: accepts code units, classifies them and queues them for the sequencer.
module fcp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [15:0]        code_unit,
   input  logic               end_of_text,
   output logic               full,
   input  logic               q_pop,
   output fcp_pkg::item_type  q_item,
   output logic               q_empty
);
   localparam int ItemW = $bits(fcp_pkg::item_type);

   fcp_pkg::item_type item_in;
   logic [ItemW-1:0]  head;

   always_comb begin
      item_in.cls = fcp_pkg::classify(code_unit);
      item_in.fin = end_of_text;
   end

   fcp_fifo #(.WIDTH(ItemW), .DEPTH(2)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (item_in),
      .full_o  (full),
      .pop_i   (q_pop),
      .data_o  (head),
      .empty_o (q_empty)
   );

   assign q_item = fcp_pkg::item_type'(head);
endmodule

// File: src/fcp_back.sv
// Back stage: lookahead buffer, style state and the scan sequencer that emits results.
module fcp_back #(
   parameter int LOOKAHEAD_DEPTH = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          scheme_count,
   input  fcp_pkg::item_type   q_item,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                out_push,
   output fcp_pkg::result_type out_data,
   input  logic                out_full
);
   localparam int D  = LOOKAHEAD_DEPTH;
   localparam int IW = $clog2(D);
   localparam int CW = $clog2(D + 1);

   typedef enum logic [2:0] {TP_HASH, TP_X, TP_Y, TP_PAL, TP_FLAG, TP_SHORT, TP_FAIL} path_type;
   typedef enum logic [1:0] {TR_NEED, TR_OK, TR_FAIL} try_type;

   fcp_pkg::state_type state_ff, state_in;
   fcp_pkg::unit_type  buf_ff [D];
   fcp_pkg::unit_type  buf_in [D];
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [4:0]         flags_ff, flags_in;
   logic [1:0]         mode_ff, mode_in;
   logic [15:0]        col_ff, col_in;
   logic [6:0]         sch_ff, sch_in;
   logic               merge_ff, merge_in;
   logic               fin_ff;
   fcp_pkg::result_type hold_ff, rec;
   logic               hold_v_ff;

   // Code recognition at buffer head.
   path_type    path;
   try_type     tr;
   logic [2:0]  tr_n;
   logic        tr_clr;
   logic [4:0]  t_flags;
   logic [1:0]  t_mode;
   logic [15:0] t_col;
   logic [6:0]  t_sch;
   logic [2:0]  lo, hi;
   logic        dec, found;
   logic [6:0]  yval;

   logic        special, emit, done, load, adv, stall;
   logic        ekind;
   logic [15:0] echar;
   logic [2:0]  cons;
   int          j;

   fcp_pkg::unit_type s0, s1;
   assign s0 = buf_ff[0];
   assign s1 = buf_ff[1];
   assign special = s0.is_sect || s0.is_hash;

   always_comb begin
      if (s0.is_hash) path = TP_HASH;
      else if (cnt_ff < CW'(2)) path = TP_SHORT;
      else if (s1.letter == fcp_pkg::LT_X) path = TP_X;
      else if (s1.hex_ok) path = TP_PAL;
      else if (s1.letter == fcp_pkg::LT_Y) path = TP_Y;
      else if (s1.letter inside {fcp_pkg::LT_L, fcp_pkg::LT_M, fcp_pkg::LT_N,
                                 fcp_pkg::LT_K, fcp_pkg::LT_R}) path = TP_FLAG;
      else path = TP_FAIL;

      case (path)
         TP_HASH: begin lo = 3'd1; hi = 3'd6; dec = 1'b0; end
         TP_X:    begin lo = 3'd2; hi = 3'd5; dec = 1'b0; end
         TP_Y:    begin lo = 3'd2; hi = 3'd3; dec = 1'b1; end
         default: begin lo = 3'd7; hi = 3'd0; dec = 1'b0; end
      endcase

      // The code fails at the first digit position that is wrong, or missing at end of text.
      found = 1'b0;
      tr    = TR_OK;
      for (int i = 1; i <= 6; i++) begin
         if (!found && 3'(i) >= lo && 3'(i) <= hi) begin
            if (CW'(i) >= cnt_ff) begin
               found = 1'b1;
               tr    = fin_ff ? TR_FAIL : TR_NEED;
            end else if (!buf_ff[i].hex_ok || (dec && buf_ff[i].hex_val > 4'd9)) begin
               found = 1'b1;
               tr    = TR_FAIL;
            end
         end
      end
      if (path == TP_SHORT) tr = fin_ff ? TR_FAIL : TR_NEED;
      if (path == TP_FAIL) tr = TR_FAIL;

      yval = {buf_ff[2].hex_val, 3'b000} + {2'b00, buf_ff[2].hex_val, 1'b0}
           + {3'b000, buf_ff[3].hex_val};

      t_flags = flags_ff;
      t_mode  = fcp_pkg::CM_DIRECT;
      t_col   = 16'd0;
      t_sch   = 7'd0;
      tr_clr  = 1'b0;
      tr_n    = 3'd2;
      if (path != TP_FLAG) begin
         t_flags[fcp_pkg::FB_BOLD]   = 1'b0;
         t_flags[fcp_pkg::FB_STRIKE] = 1'b0;
         t_flags[fcp_pkg::FB_UNDER]  = 1'b0;
      end
      case (path)
         TP_HASH: begin
            tr_n  = 3'd7;
            t_col = {buf_ff[1].hex_val, buf_ff[2].hex_val[3], buf_ff[3].hex_val,
                     buf_ff[4].hex_val[3:2], buf_ff[5].hex_val, buf_ff[6].hex_val[3]};
         end
         TP_X: begin
            tr_n  = 3'd6;
            t_col = {buf_ff[2].hex_val, buf_ff[3].hex_val, buf_ff[4].hex_val,
                     buf_ff[5].hex_val};
         end
         TP_PAL: t_col = fcp_pkg::PALETTE[s1.hex_val];
         TP_Y: begin
            tr_n = 3'd4;
            if ({1'b0, yval} < scheme_count) begin
               t_mode = fcp_pkg::CM_SCHEME;
               t_sch  = yval;
            end
         end
         TP_FLAG: begin
            t_mode = mode_ff;
            t_col  = col_ff;
            t_sch  = sch_ff;
            case (s1.letter)
               fcp_pkg::LT_L: t_flags = flags_ff | 5'b00011;
               fcp_pkg::LT_M: t_flags = flags_ff | 5'b00101;
               fcp_pkg::LT_N: t_flags = flags_ff | 5'b01001;
               fcp_pkg::LT_K: t_flags = flags_ff | 5'b10001;
               default: begin
                  t_flags = 5'd0;
                  t_mode  = fcp_pkg::CM_NONE;
                  t_col   = 16'd0;
                  t_sch   = 7'd0;
                  tr_clr  = 1'b1;
               end
            endcase
         end
         default: ;
      endcase
   end

   // One scan step of the sequencer.
   always_comb begin
      flags_in = flags_ff;
      mode_in  = mode_ff;
      col_in   = col_ff;
      sch_in   = sch_ff;
      merge_in = merge_ff;
      emit     = 1'b0;
      ekind    = fcp_pkg::KIND_EVENT;
      echar    = fcp_pkg::EVENT_CHAR;
      done     = 1'b0;
      cons     = 3'd0;
      if (!merge_ff) begin
         if (cnt_ff == '0) begin
            done = 1'b1;
         end else if (!special) begin
            emit = 1'b1; ekind = fcp_pkg::KIND_LITERAL; echar = s0.unit; cons = 3'd1;
         end else if (cnt_ff < CW'(2) && !fin_ff) begin
            done = 1'b1;
         end else if (cnt_ff >= CW'(2) && s1.unit == s0.unit) begin
            emit = 1'b1; ekind = fcp_pkg::KIND_LITERAL; echar = s0.unit; cons = 3'd2;
         end else begin
            case (tr)
               TR_NEED: done = 1'b1;
               TR_FAIL: begin
                  emit = 1'b1; ekind = fcp_pkg::KIND_LITERAL; echar = s0.unit; cons = 3'd1;
               end
               default: begin
                  flags_in = t_flags; mode_in = t_mode; col_in = t_col; sch_in = t_sch;
                  cons = tr_n;
                  if (tr_clr) emit = 1'b1;
                  else merge_in = 1'b1;
               end
            endcase
         end
      end else begin
         if (cnt_ff == '0) begin
            if (!fin_ff) done = 1'b1;
            else begin emit = 1'b1; merge_in = 1'b0; end
         end else if (!special) begin
            emit = 1'b1; merge_in = 1'b0;
         end else begin
            case (tr)
               TR_NEED: done = 1'b1;
               TR_FAIL: begin emit = 1'b1; merge_in = 1'b0; end
               default: begin
                  flags_in = t_flags; mode_in = t_mode; col_in = t_col; sch_in = t_sch;
                  cons = tr_n;
                  if (tr_clr) begin emit = 1'b1; merge_in = 1'b0; end
               end
            endcase
         end
      end

      for (int i = 0; i < D; i++) begin
         j = i + int'(cons);
         buf_in[i] = (j < D) ? buf_ff[IW'(j)] : buf_ff[i];
      end
      cnt_in = cnt_ff - CW'(cons);

      // End of text: everything clears and a closing event shows the cleared style.
      if (done && fin_ff) begin
         cnt_in   = '0;
         flags_in = 5'd0;
         mode_in  = fcp_pkg::CM_NONE;
         col_in   = 16'd0;
         sch_in   = 7'd0;
         merge_in = 1'b0;
         emit     = 1'b1;
         ekind    = fcp_pkg::KIND_EVENT;
         echar    = fcp_pkg::EVENT_CHAR;
      end

      rec.kind         = ekind;
      rec.char_out     = echar;
      rec.flags        = flags_in;
      rec.color_mode   = mode_in;
      rec.color565     = (mode_in == fcp_pkg::CM_DIRECT) ? col_in : 16'd0;
      rec.scheme_index = (mode_in == fcp_pkg::CM_SCHEME) ? sch_in : 7'd0;
      rec.text_end     = fin_ff;
      rec.last         = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcp_pkg::ST_IDLE: if (!q_empty) state_in = fcp_pkg::ST_RUN;
         fcp_pkg::ST_RUN:  if (adv && done) state_in = fcp_pkg::ST_END;
         fcp_pkg::ST_END:  if (!hold_v_ff || !out_full) state_in = fcp_pkg::ST_IDLE;
         default:          state_in = fcp_pkg::ST_IDLE;
      endcase
   end

   // The newest result is held back until the next one shows whether it was the last.
   always_comb begin
      load     = (state_ff == fcp_pkg::ST_IDLE) && !q_empty;
      q_pop    = load;
      stall    = emit && hold_v_ff && out_full;
      adv      = (state_ff == fcp_pkg::ST_RUN) && !stall;
      out_data = hold_ff;
      out_data.last = (state_ff == fcp_pkg::ST_END);
      case (state_ff)
         fcp_pkg::ST_RUN: out_push = adv && emit && hold_v_ff;
         fcp_pkg::ST_END: out_push = hold_v_ff && !out_full;
         default:         out_push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fcp_pkg::ST_IDLE;
         cnt_ff    <= '0;
         flags_ff  <= 5'd0;
         mode_ff   <= fcp_pkg::CM_NONE;
         col_ff    <= 16'd0;
         sch_ff    <= 7'd0;
         merge_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            fin_ff <= q_item.fin;
            if (cnt_ff < CW'(D)) cnt_ff <= cnt_ff + 1'b1;
         end
         if (adv) begin
            cnt_ff   <= cnt_in;
            flags_ff <= flags_in;
            mode_ff  <= mode_in;
            col_ff   <= col_in;
            sch_ff   <= sch_in;
            merge_ff <= merge_in;
            if (emit) hold_v_ff <= 1'b1;
         end
         if (state_ff == fcp_pkg::ST_END && out_push) hold_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && cnt_ff < CW'(D)) buf_ff[cnt_ff[IW-1:0]] <= q_item.cls;
      if (adv) buf_ff <= buf_in;
      if (adv && emit) hold_ff <= rec;
   end
endmodule

// File: src/fcp_checker.sv
// Port-level checks of the format code text parser and their binding to the top level.
module fcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        rsp_kind,
   input logic [15:0] rsp_char_out,
   input logic [1:0]  rsp_color_mode,
   input logic [15:0] rsp_color565,
   input logic [6:0]  rsp_scheme_index
);
   // Reset drops every waiting result.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("results remain after reset");

   a_event_char: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == fcp_pkg::KIND_EVENT) |-> rsp_char_out == fcp_pkg::EVENT_CHAR)
      else $error("style event without event character");

   a_color_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_color_mode != fcp_pkg::CM_DIRECT) |-> rsp_color565 == 16'd0)
      else $error("colour value outside direct mode");

   a_scheme_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_color_mode != fcp_pkg::CM_SCHEME) |-> rsp_scheme_index == 7'd0)
      else $error("scheme index outside scheme mode");
endmodule

bind format_code_text_parser_core fcp_checker u_checker (.*);
